// ----- sv/assert_macros.svh -----
// Assertion macros used by the datapath of the hazard reorder block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/hrn_pkg.sv -----
// Shared constants, types and decode functions of the hazard reorder block.
package hrn_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [31:0] NOP_WORD = 32'h0000_0013;
   localparam logic [6:0] OP_RTYPE = 7'b0110011;
   localparam logic [6:0] OP_ITYPE = 7'b0010011;
   localparam logic [6:0] OP_LOAD  = 7'b0000011;
   localparam logic [6:0] OP_STORE = 7'b0100011;
   localparam logic [4:0] REG_ZERO = 5'b00000;

   localparam logic REQ_SCHED = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT_W,
      ST_FLUSH,
      ST_FLUSH_W
   } state_type;

   typedef enum logic [1:0] {
      SEL_WORD,
      SEL_QUEUE,
      SEL_NOP
   } sel_type;

   typedef struct packed {
      logic [4:0] rd;
      logic [4:0] rs1;
      logic [4:0] rs2;
      logic       load;
   } dec_type;

   typedef struct packed {
      logic    load_in;
      logic    idx_clear;
      logic    idx_inc;
      logic    emit;
      sel_type sel;
      logic    emit_last;
      logic    remove;
      logic    push;
      logic    flush_done;
   } cmd_type;

   typedef struct packed {
      logic is_flush;
      logic word_haz;
      logic entry_haz;
      logic word_haz_entry;
      logic idx_at_count;
      logic idx_at_last;
      logic out_free;
   } status_type;

   function automatic dec_type decode(input logic [31:0] w);
      dec_type d;
      d.rd   = w[11:7];
      d.rs1  = w[19:15];
      d.rs2  = w[24:20];
      d.load = (w[6:0] == OP_LOAD);
      case (w[6:0])
         OP_RTYPE: begin
         end
         OP_ITYPE, OP_LOAD: begin
            d.rs2 = REG_ZERO;
         end
         OP_STORE: begin
            d.rd = REG_ZERO;
         end
         default: begin
            d.rd  = REG_ZERO;
            d.rs1 = REG_ZERO;
            d.rs2 = REG_ZERO;
         end
      endcase
      return d;
   endfunction

   // WAW against the previous destination, or a read of a register that a load writes.
   function automatic logic hazard(input logic [31:0] w, input logic [4:0] pdest,
                                   input logic pload);
      dec_type d;
      d = decode(w);
      return ((d.rd != REG_ZERO) && (d.rd == pdest)) ||
             (pload && (pdest != REG_ZERO) && ((d.rs1 == pdest) || (d.rs2 == pdest)));
   endfunction

endpackage

// ----- sv/hrn_req_if.sv -----
// Input channel interface: valid/ready handshake with opcode and instruction word.
interface hrn_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] instr_word;

   modport source (output valid, output opcode, output instr_word, input ready);
   modport sink (input valid, input opcode, input instr_word, output ready);
endinterface

// ----- sv/hrn_rsp_if.sv -----
// Result channel interface: valid/ready handshake with the emitted word and its flags.
interface hrn_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_word;
   logic        is_nop;
   logic        from_queue;
   logic        overflow;
   logic        last;

   modport source (output valid, output out_word, output is_nop, output from_queue,
                   output overflow, output last, input ready);
   modport sink (input valid, input out_word, input is_nop, input from_queue,
                 input overflow, input last, output ready);
endinterface

// ----- sv/hazard_reorder_nop_inserter_unit.sv -----
// Top level of the hazard reorder and NOP insertion block.
//
// The req channel carries one transaction per input item: opcode 0 schedules
// instr_word, opcode 1 flushes the holding queue. The rsp channel returns the
// emitted words one transaction each; last marks the final result of an item.
// A flush of an empty queue returns no result and only clears the record.
// An item is taken in the idle state, then checked in the check state. A word
// free of hazard is emitted from the check state. A hazardous word examines
// the queued entries in order (up to the queue depth of 8) and emits the first
// one free of hazard, or a NOP if none is, then the word unless it is parked.
// A flush emits each queued word in order, with a NOP before any that clashes,
// then clears the queue and the record. One item is in flight at a time.
// The result register lets the last result of an item wait while the next
// item is accepted. A receiver stall pauses emission and holds the state machine,
// though a scan still steps past hazardous entries. Synchronous reset empties
// the queue, clears the previous-instruction record, drops any pending result.
module hazard_reorder_nop_inserter_unit (
   input logic   clock,
   input logic   reset,
   hrn_req_if.sink   req_chan,
   hrn_rsp_if.source rsp_chan
);

   hrn_pkg::cmd_type    cmd;
   hrn_pkg::status_type status;

   hrn_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hrn_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_chan.opcode),
      .req_instr_word (req_chan.instr_word),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_out_word   (rsp_chan.out_word),
      .rsp_is_nop     (rsp_chan.is_nop),
      .rsp_from_queue (rsp_chan.from_queue),
      .rsp_overflow   (rsp_chan.overflow),
      .rsp_last       (rsp_chan.last)
   );

endmodule

// ----- sv/hrn_datapath.sv -----
// Datapath: input latch, previous-instruction record, holding queue and result register.
`include "assert_macros.svh"

module hrn_datapath (
   input  logic                clock,
   input  logic                reset,
   input  hrn_pkg::cmd_type    cmd,
   output hrn_pkg::status_type status,
   input  logic                req_opcode,
   input  logic [31:0]         req_instr_word,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [31:0]         rsp_out_word,
   output logic                rsp_is_nop,
   output logic                rsp_from_queue,
   output logic                rsp_overflow,
   output logic                rsp_last
);

   logic                      op_ff;
   logic [31:0]               word_ff;
   logic [4:0]                prev_dest_ff;
   logic                      prev_load_ff;
   logic [31:0]               queue_ff [hrn_pkg::QUEUE_DEPTH];
   logic [31:0]               upper [hrn_pkg::QUEUE_DEPTH];
   logic [hrn_pkg::CNT_W-1:0] count_ff;
   logic [hrn_pkg::CNT_W-1:0] count_in;
   logic [hrn_pkg::CNT_W-1:0] push_pos;
   logic [hrn_pkg::CNT_W-1:0] idx_ff;
   logic [31:0]               entry;
   hrn_pkg::dec_type          entry_dec;
   hrn_pkg::dec_type          emit_dec;
   logic [31:0]               emit_word;

   logic                      rsp_valid_ff;
   logic [31:0]               rsp_word_ff;
   logic                      rsp_is_nop_ff;
   logic                      rsp_from_queue_ff;
   logic                      rsp_last_ff;

   assign entry     = queue_ff[idx_ff[hrn_pkg::IDX_W-1:0]];
   assign entry_dec = hrn_pkg::decode(entry);

   always_comb begin
      status.is_flush       = (op_ff == hrn_pkg::REQ_FLUSH);
      status.word_haz       = hrn_pkg::hazard(word_ff, prev_dest_ff, prev_load_ff);
      status.entry_haz      = hrn_pkg::hazard(entry, prev_dest_ff, prev_load_ff);
      status.word_haz_entry = hrn_pkg::hazard(word_ff, entry_dec.rd, entry_dec.load);
      status.idx_at_count   = (idx_ff == count_ff);
      status.idx_at_last    = (hrn_pkg::CNT_W'(idx_ff + 1'b1) == count_ff);
      status.out_free       = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      case (cmd.sel)
         hrn_pkg::SEL_WORD:  emit_word = word_ff;
         hrn_pkg::SEL_QUEUE: emit_word = entry;
         hrn_pkg::SEL_NOP:   emit_word = hrn_pkg::NOP_WORD;
         default:            emit_word = hrn_pkg::NOP_WORD;
      endcase
   end
   assign emit_dec = hrn_pkg::decode(emit_word);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff   <= req_opcode;
         word_ff <= req_instr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_dest_ff <= hrn_pkg::REG_ZERO;
         prev_load_ff <= 1'b0;
      end else if (cmd.flush_done || (cmd.emit && cmd.sel == hrn_pkg::SEL_NOP)) begin
         prev_dest_ff <= hrn_pkg::REG_ZERO;
         prev_load_ff <= 1'b0;
      end else if (cmd.emit) begin
         prev_dest_ff <= emit_dec.rd;
         prev_load_ff <= emit_dec.load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= hrn_pkg::CNT_W'(idx_ff + 1'b1);
      end
   end

   // Each entry's neighbor toward the tail, used when an entry is taken out.
   for (genvar j = 0; j < hrn_pkg::QUEUE_DEPTH; j++) begin : g_upper
      if (j < hrn_pkg::QUEUE_DEPTH - 1) begin : g_mid
         assign upper[j] = queue_ff[j + 1];
      end else begin : g_top
         assign upper[j] = queue_ff[j];
      end
   end

   // A push always comes with a removal, so the queue always has room for it.
   assign push_pos = cmd.remove ? hrn_pkg::CNT_W'(count_ff - 1'b1) : count_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < hrn_pkg::QUEUE_DEPTH; j++) begin
         if (cmd.remove && (hrn_pkg::CNT_W'(j) >= idx_ff)) begin
            queue_ff[j] <= upper[j];
         end
         if (cmd.push && (hrn_pkg::CNT_W'(j) == push_pos)) begin
            queue_ff[j] <= word_ff;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.flush_done) begin
         count_in = '0;
      end else begin
         if (cmd.remove) begin
            count_in = hrn_pkg::CNT_W'(count_in - 1'b1);
         end
         if (cmd.push && (push_pos < hrn_pkg::CNT_W'(hrn_pkg::QUEUE_DEPTH))) begin
            count_in = hrn_pkg::CNT_W'(count_in + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_word_ff       <= emit_word;
         rsp_is_nop_ff     <= (cmd.sel == hrn_pkg::SEL_NOP);
         rsp_from_queue_ff <= (cmd.sel == hrn_pkg::SEL_QUEUE);
         rsp_last_ff       <= cmd.emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_word   = rsp_word_ff;
   assign rsp_is_nop     = rsp_is_nop_ff;
   assign rsp_from_queue = rsp_from_queue_ff;
   // A forced word needs a full queue at a push, and every push comes with a removal.
   assign rsp_overflow   = 1'b0;
   assign rsp_last       = rsp_last_ff;

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
                count_ff <= hrn_pkg::CNT_W'(hrn_pkg::QUEUE_DEPTH))
   `ASSERT_IMPL(a_nop_form, clock, reset, rsp_valid_ff && rsp_is_nop_ff,
                (rsp_word_ff == hrn_pkg::NOP_WORD) && !rsp_from_queue_ff)
   `ASSERT_NEXT(a_remove_count, clock, reset, cmd.remove && !cmd.push && !cmd.flush_done,
                count_ff == $past(count_ff) - 1'b1)
   `ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid_ff)

endmodule

// ----- sv/hrn_controller.sv -----
// Controller state machine that sequences checks, queue scans and emissions.
module hrn_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hrn_pkg::status_type status,
   output hrn_pkg::cmd_type    cmd
);

   hrn_pkg::state_type state_ff;
   hrn_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hrn_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = hrn_pkg::ST_CHECK;
            end
         end
         hrn_pkg::ST_CHECK: begin
            if (status.is_flush) begin
               state_in = hrn_pkg::ST_FLUSH;
            end else if (status.word_haz) begin
               state_in = hrn_pkg::ST_SCAN;
            end else if (status.out_free) begin
               state_in = hrn_pkg::ST_IDLE;
            end
         end
         hrn_pkg::ST_SCAN: begin
            if (status.idx_at_count) begin
               if (status.out_free) begin
                  state_in = hrn_pkg::ST_EMIT_W;
               end
            end else if (!status.entry_haz && status.out_free) begin
               state_in = status.word_haz_entry ? hrn_pkg::ST_IDLE : hrn_pkg::ST_EMIT_W;
            end
         end
         hrn_pkg::ST_EMIT_W: begin
            if (status.out_free) begin
               state_in = hrn_pkg::ST_IDLE;
            end
         end
         hrn_pkg::ST_FLUSH: begin
            if (status.idx_at_count) begin
               state_in = hrn_pkg::ST_IDLE;
            end else if (status.entry_haz && status.out_free) begin
               state_in = hrn_pkg::ST_FLUSH_W;
            end
         end
         hrn_pkg::ST_FLUSH_W: begin
            if (status.out_free) begin
               state_in = hrn_pkg::ST_FLUSH;
            end
         end
         default: begin
            state_in = hrn_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.sel   = hrn_pkg::SEL_WORD;
      req_ready = 1'b0;
      case (state_ff)
         hrn_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_in   = req_valid;
            cmd.idx_clear = req_valid;
         end
         hrn_pkg::ST_CHECK: begin
            if (!status.is_flush && !status.word_haz && status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = hrn_pkg::SEL_WORD;
               cmd.emit_last = 1'b1;
            end
         end
         hrn_pkg::ST_SCAN: begin
            if (status.idx_at_count) begin
               // No queued word is free of hazard: a NOP clears the record.
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.sel  = hrn_pkg::SEL_NOP;
               end
            end else if (status.entry_haz) begin
               cmd.idx_inc = 1'b1;
            end else if (status.out_free) begin
               // The new word is parked in the queue if it clashes with the entry.
               cmd.emit      = 1'b1;
               cmd.sel       = hrn_pkg::SEL_QUEUE;
               cmd.remove    = 1'b1;
               cmd.emit_last = status.word_haz_entry;
               cmd.push      = status.word_haz_entry;
            end
         end
         hrn_pkg::ST_EMIT_W: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = hrn_pkg::SEL_WORD;
               cmd.emit_last = 1'b1;
            end
         end
         hrn_pkg::ST_FLUSH: begin
            if (status.idx_at_count) begin
               cmd.flush_done = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.entry_haz) begin
                  cmd.sel = hrn_pkg::SEL_NOP;
               end else begin
                  cmd.sel       = hrn_pkg::SEL_QUEUE;
                  cmd.emit_last = status.idx_at_last;
                  cmd.idx_inc   = 1'b1;
               end
            end
         end
         hrn_pkg::ST_FLUSH_W: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = hrn_pkg::SEL_QUEUE;
               cmd.emit_last = status.idx_at_last;
               cmd.idx_inc   = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- tb/hazard_reorder_checker.sv -----
// Checker that predicts and compares the emitted instruction stream of the hazard reorder block.
`timescale 1ns / 1ps

module hazard_reorder_checker
   import hrn_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hrn_req_if   req_mon,
   hrn_rsp_if   rsp_mon,
   output int   fail_count,
   output int   waiting,
   output int   results_seen,
   output int   nops_seen
);

   typedef struct packed {
      logic [31:0] word;
      logic        nop;
      logic        queued;
      logic        forced;
      logic        last;
   } emit_rec_type;

   emit_rec_type due_words[$];
   logic [31:0]  held_words[$];
   logic [4:0]   last_rd = REG_ZERO;
   logic         last_load = 1'b0;
   int           errors = 0;
   int           checked = 0;
   int           nops = 0;

   function automatic void fields_of(input logic [31:0] w, output logic [4:0] rd,
                                     output logic [4:0] rs1, output logic [4:0] rs2,
                                     output logic ld);
      ld  = (w[6:0] == OP_LOAD);
      rd  = REG_ZERO;
      rs1 = REG_ZERO;
      rs2 = REG_ZERO;
      case (w[6:0])
         OP_RTYPE: begin
            rd  = w[11:7];
            rs1 = w[19:15];
            rs2 = w[24:20];
         end
         OP_ITYPE, OP_LOAD: begin
            rd  = w[11:7];
            rs1 = w[19:15];
         end
         OP_STORE: begin
            rs1 = w[19:15];
            rs2 = w[24:20];
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic conflicts(input logic [31:0] w);
      logic [4:0] rd, rs1, rs2;
      logic       ld;
      fields_of(w, rd, rs1, rs2, ld);
      if (rd != REG_ZERO && rd == last_rd)
         return 1'b1;
      return last_load && last_rd != REG_ZERO && (rs1 == last_rd || rs2 == last_rd);
   endfunction

   function automatic void record(input logic [31:0] w);
      logic [4:0] rd, rs1, rs2;
      logic       ld;
      fields_of(w, rd, rs1, rs2, ld);
      last_rd   = rd;
      last_load = ld;
   endfunction

   function automatic void forget();
      last_rd   = REG_ZERO;
      last_load = 1'b0;
   endfunction

   function automatic emit_rec_type mk(input logic [31:0] w, input logic nop,
                                       input logic queued, input logic forced);
      emit_rec_type r;
      r.word   = w;
      r.nop    = nop;
      r.queued = queued;
      r.forced = forced;
      r.last   = 1'b0;
      return r;
   endfunction

   // Works out every result one accepted transaction causes and appends them in order.
   task automatic schedule_item(input logic op, input logic [31:0] w);
      emit_rec_type batch[$];
      logic         hit;
      int           i;
      if (op == REQ_SCHED) begin
         if (conflicts(w)) begin
            hit = 1'b0;
            i = 0;
            while (!hit && i < held_words.size()) begin
               if (!conflicts(held_words[i])) begin
                  batch.insert(batch.size(), mk(held_words[i], 1'b0, 1'b1, 1'b0));
                  record(held_words[i]);
                  held_words.delete(i);
                  hit = 1'b1;
               end else begin
                  i++;
               end
            end
            if (!hit) begin
               batch.insert(batch.size(), mk(NOP_WORD, 1'b1, 1'b0, 1'b0));
               forget();
            end
         end
         if (conflicts(w)) begin
            if (held_words.size() < QUEUE_DEPTH) begin
               held_words.insert(held_words.size(), w);
            end else begin
               batch.insert(batch.size(), mk(NOP_WORD, 1'b1, 1'b0, 1'b0));
               forget();
               batch.insert(batch.size(), mk(w, 1'b0, 1'b0, 1'b1));
               record(w);
            end
         end else begin
            batch.insert(batch.size(), mk(w, 1'b0, 1'b0, 1'b0));
            record(w);
         end
      end else begin
         for (i = 0; i < held_words.size(); i++) begin
            if (conflicts(held_words[i])) begin
               batch.insert(batch.size(), mk(NOP_WORD, 1'b1, 1'b0, 1'b0));
               forget();
            end
            batch.insert(batch.size(), mk(held_words[i], 1'b0, 1'b1, 1'b0));
            record(held_words[i]);
         end
         held_words.delete();
         forget();
      end
      if (batch.size() > 0)
         batch[batch.size() - 1].last = 1'b1;
      for (i = 0; i < batch.size(); i++)
         due_words.insert(due_words.size(), batch[i]);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t, result %0d, %s: got %h, expected %h",
               $realtime, checked, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      emit_rec_type want;
      if (reset) begin
         due_words.delete();
         held_words.delete();
         forget();
      end else begin
         // Results are matched before the new transaction is predicted, so a result
         // arriving with nothing queued is never covered by a fresh prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_words.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_mon.out_word, 32'h0);
            end else begin
               want = due_words.pop_front();
               if (rsp_mon.out_word !== want.word)
                  report_mismatch("out_word", rsp_mon.out_word, want.word);
               if (rsp_mon.is_nop !== want.nop)
                  report_mismatch("is_nop", 32'(rsp_mon.is_nop), 32'(want.nop));
               if (rsp_mon.from_queue !== want.queued)
                  report_mismatch("from_queue", 32'(rsp_mon.from_queue), 32'(want.queued));
               if (rsp_mon.overflow !== want.forced)
                  report_mismatch("overflow", 32'(rsp_mon.overflow), 32'(want.forced));
               if (rsp_mon.last !== want.last)
                  report_mismatch("last", 32'(rsp_mon.last), 32'(want.last));
               checked++;
               if (want.nop)
                  nops++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            schedule_item(req_mon.opcode, req_mon.instr_word);
      end
      fail_count   <= errors;
      waiting      <= due_words.size();
      results_seen <= checked;
      nops_seen    <= nops;
   end

endmodule

// ----- tb/hazard_reorder_nop_inserter_unit_test.sv -----
// Stimulus, flow control and verdict for the hazard reorder and NOP insertion block.
`timescale 1ns / 1ps

module hazard_reorder_nop_inserter_unit_test;
   import hrn_pkg::*;

   localparam int          LIMIT_CYCLES = 200000;
   localparam int          TAIL_CYCLES = 40;
   localparam int          HOLD_CYCLES = 250;
   localparam int          PHASE_ITEMS = 50;
   localparam logic [6:0]  OP_JAL = 7'b1101111;

   logic clock;
   logic reset;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   hold_token = 0;
   int   items_sent = 0;
   int   flushes_sent = 0;
   int   fail_count, waiting, results_seen, nops_seen;

   hrn_req_if req_chan ();
   hrn_rsp_if rsp_chan ();

   hazard_reorder_nop_inserter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hazard_reorder_checker emit_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .fail_count   (fail_count),
      .waiting      (waiting),
      .results_seen (results_seen),
      .nops_seen    (nops_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver starts a long hold-off whenever the stimulus bumps the token.
   initial begin : receiver
      int left;
      int seen;
      left = 0;
      seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token != seen) begin
            seen = hold_token;
            left = HOLD_CYCLES;
         end
         if (left > 0) begin
            left--;
            rsp_chan.ready <= 1'b0;
         end else if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results outstanding", LIMIT_CYCLES, waiting);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [31:0] build_word(input logic [6:0] op, input logic [4:0] rd,
                                              input logic [4:0] rs1, input logic [4:0] rs2);
      logic [31:0] w;
      w = $urandom;
      w[6:0]   = op;
      w[11:7]  = rd;
      w[19:15] = rs1;
      w[24:20] = rs2;
      return w;
   endfunction

   // Registers come mostly from a small pool so that hazards are frequent.
   function automatic logic [31:0] pick_word();
      int         kind;
      int         reg_max;
      logic [6:0] op;
      kind = $urandom_range(99);
      reg_max = ($urandom_range(4) == 0) ? 31 : 3;
      if (kind < 10)
         return $urandom;
      if (kind < 38)
         op = OP_RTYPE;
      else if (kind < 56)
         op = OP_ITYPE;
      else if (kind < 78)
         op = OP_LOAD;
      else if (kind < 92)
         op = OP_STORE;
      else
         op = OP_JAL;
      return build_word(op, 5'($urandom_range(reg_max)), 5'($urandom_range(reg_max)),
                        5'($urandom_range(reg_max)));
   endfunction

   task automatic send_item(input logic op, input logic [31:0] w);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.instr_word <= w;
      do
         @(posedge clock);
      while (!req_chan.ready);
      items_sent++;
      if (op == REQ_FLUSH)
         flushes_sent++;
   endtask

   // The sender stays quiet until every predicted result has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do
         @(posedge clock);
      while (waiting != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      int i;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8)
            send_item(REQ_FLUSH, $urandom);
         else
            send_item(REQ_SCHED, pick_word());
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.opcode     <= REQ_SCHED;
      req_chan.instr_word <= 32'h0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: write-after-write, load-use on each source, x0 and x31, other opcodes,
      // the NOP word itself, and flushes of an empty queue with garbage in the word.
      send_item(REQ_SCHED, build_word(OP_RTYPE, 5'd5, 5'd1, 5'd2));
      send_item(REQ_SCHED, build_word(OP_RTYPE, 5'd5, 5'd3, 5'd4));
      send_item(REQ_SCHED, build_word(OP_LOAD, 5'd7, 5'd5, 5'd0));
      send_item(REQ_SCHED, build_word(OP_RTYPE, 5'd8, 5'd7, 5'd9));
      send_item(REQ_SCHED, build_word(OP_LOAD, 5'd31, 5'd0, 5'd0));
      send_item(REQ_SCHED, build_word(OP_STORE, 5'd0, 5'd1, 5'd31));
      send_item(REQ_SCHED, build_word(OP_LOAD, 5'd0, 5'd2, 5'd0));
      send_item(REQ_SCHED, build_word(OP_RTYPE, 5'd3, 5'd0, 5'd0));
      send_item(REQ_SCHED, build_word(OP_ITYPE, 5'd3, 5'd3, 5'd0));
      send_item(REQ_SCHED, NOP_WORD);
      send_item(REQ_SCHED, 32'hFFFF_FFFF);
      send_item(REQ_SCHED, 32'h0000_0000);
      send_item(REQ_FLUSH, 32'hFFFF_FFFF);
      send_item(REQ_SCHED, build_word(OP_LOAD, 5'd31, 5'd31, 5'd0));
      send_item(REQ_SCHED, build_word(OP_LOAD, 5'd31, 5'd31, 5'd0));
      send_item(REQ_SCHED, build_word(OP_ITYPE, 5'd1, 5'd31, 5'd0));
      send_item(REQ_SCHED, build_word(OP_JAL, 5'd1, 5'd1, 5'd1));
      send_item(REQ_FLUSH, 32'h0000_0000);
      send_item(REQ_FLUSH, 32'h8000_0001);
      send_item(REQ_SCHED, build_word(OP_STORE, 5'd31, 5'd31, 5'd31));
      drain_results();

      // Back-to-back traffic while the receiver holds off, so the block backs up.
      hold_token <= hold_token + 1;
      random_phase(PHASE_ITEMS);
      drain_results();

      idle_pct  <= 62;
      random_phase(PHASE_ITEMS);
      drain_results();

      idle_pct  <= 0;
      stall_pct <= 62;
      random_phase(PHASE_ITEMS);
      drain_results();

      idle_pct  <= 33;
      stall_pct <= 33;
      random_phase(PHASE_ITEMS);
      drain_results();

      $display("Sent %0d transactions (%0d flushes) across idle and stall mixes.",
               items_sent, flushes_sent);
      $display("Checked %0d results, %0d of them inserted NOPs.", results_seen, nops_seen);
      if (fail_count == 0 && waiting == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/hrn_pkg.sv
sv/hrn_req_if.sv
sv/hrn_rsp_if.sv
sv/hrn_datapath.sv
sv/hrn_controller.sv
sv/hazard_reorder_nop_inserter_unit.sv
tb/hazard_reorder_checker.sv
tb/hazard_reorder_nop_inserter_unit_test.sv
